/* design/bilateral_filter_gray_top_macros.svh */
// Assertion helpers for the bilateral filter block.
// Both sample on clk and are disabled while rst_n is low.
`ifndef BILATERAL_FILTER_GRAY_TOP_MACROS_SVH
`define BILATERAL_FILTER_GRAY_TOP_MACROS_SVH

// Same-cycle implication
`define BFG_ASSERT_SAME(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("bilateral filter: same-cycle check failed");

// Next-cycle implication
`define BFG_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("bilateral filter: next-cycle check failed");

`endif

/* design/bfg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfg_pkg
// Shared codes and helpers for the grayscale bilateral filter.
// ----------------------------------------------------------------------------
package bfg_pkg;

    // request kinds carried on s_tuser
    typedef enum logic [1:0] {
        REQ_RANGE_LOAD   = 2'd0,
        REQ_SPATIAL_LOAD = 2'd1,
        REQ_PIXEL        = 2'd2,
        REQ_FLUSH        = 2'd3
    } req_kind_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_RADIUS = 2'd2,
        CFG_NONE   = 2'd3
    } cfg_reg_t;

    localparam int CFG_DATA_BITS = 11;
    localparam int S_DATA_BITS   = 32;
    localparam int PIX_BITS      = 8;

    // floor(sqrt(v)) for v up to 255; each term is an independent compare
    function automatic logic [3:0] isqrt8(input logic [7:0] v);
        logic [3:0] s;
        s = 4'd0;
        for (int k = 1; k < 16; k++)
        begin
            if (32'(v) >= k * k)
            begin
                s = 4'(k);
            end
        end
        return s;
    endfunction

endpackage

/* design/bfg_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfg_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bfg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/bilateral_filter_gray_top.sv */
// ----------------------------------------------------------------------------
// bilateral_filter_gray_top
// Load beats are taken in idle. A pixel or flush beat that releases an output
// reads the centre pixel, then one shared multiply-accumulate walks the window
// taps (an in-image tap reads the line store and the range table; an off-image
// tap is skipped), then a serial divider makes 10 bits.
// Reset: counters to zero, size 1024x1024, radius 4; tables are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bilateral_filter_gray_top_macros.svh"

module bilateral_filter_gray_top #(
    parameter int MAX_WIDTH     = 1024,
    parameter int MAX_HEIGHT    = 1024,
    parameter int MAX_RADIUS    = 4,
    parameter int SPATIAL_DEPTH = 8,
    parameter int WEIGHT_BITS   = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // s_tdata: table_index[7:0], weight_value[23:8], pixel_in[31:24]
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bfg_pkg::S_DATA_BITS-1:0]    s_tdata,
    // s_tuser: req_type[1:0]
    input  logic [1:0]                         s_tuser,
    // m_tdata: pixel_out[7:0]; m_tlast: frame_last
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bfg_pkg::PIX_BITS-1:0]       m_tdata,
    output logic                               m_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [1:0]                         cfg_index,
    input  logic [bfg_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 1);
    localparam int RING  = 2 * MAX_RADIUS + 2;
    localparam int RGW   = $clog2(RING);
    localparam int LDEP  = RING * MAX_WIDTH;
    localparam int LAW   = $clog2(LDEP);
    localparam int SIW   = (SPATIAL_DEPTH > 1) ? $clog2(SPATIAL_DEPTH) : 1;
    localparam int RDW   = $clog2(MAX_RADIUS + 1);
    localparam int DW    = RDW + 2;
    localparam int WB    = WEIGHT_BITS;
    localparam int PW    = 2 * WB;
    localparam int TAPW  = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
    localparam int DENW  = PW + TAPW;
    localparam int NUMW  = DENW + 8;
    localparam int REMW  = NUMW + 1;
    localparam int QW    = 10;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_CTR_RD, S_CTR_CAP, S_TAP_RD, S_TAP_LINE,
        S_TAP_RANGE, S_TAP_ACC, S_DIV_INIT, S_DIV, S_EMIT
    } state_t;

    state_t           state_reg;
    logic [10:0]      cfg_width_reg;
    logic [10:0]      cfg_height_reg;
    logic [2:0]       cfg_radius_reg;
    logic [RW-1:0]    in_row_reg, out_row_reg;
    logic [CW-1:0]    in_col_reg, out_col_reg;
    logic [RGW-1:0]   in_ring_reg, out_ring_reg;
    logic             m_tvalid_reg, m_tlast_reg;
    logic [7:0]       m_tdata_reg;

    // datapath registers
    logic signed [DW-1:0] dr_reg, dc_reg;
    logic [7:0]       ip_reg, iq_reg;
    logic [WB-1:0]    ws_reg;
    logic [PW-1:0]    wt_reg;
    logic [NUMW-1:0]  num_reg;
    logic [DENW-1:0]  den_reg;
    logic [REMW-1:0]  rem_reg;
    logic [QW-1:0]    q_reg;
    logic [3:0]       div_k_reg;
    logic [WB-1:0]    spatial_reg [SPATIAL_DEPTH];

    // input beat fields
    logic [7:0]       table_index;
    logic [15:0]      weight_value;
    logic [7:0]       pixel_in;
    logic [WB-1:0]    wv;
    logic             s_fire;

    assign table_index  = s_tdata[7:0];
    assign weight_value = s_tdata[23:8];
    assign pixel_in     = s_tdata[31:24];
    assign wv           = WB'(weight_value);
    assign s_tready     = (state_reg == S_IDLE);
    assign s_fire       = s_tvalid && s_tready;
    assign cfg_ready    = 1'b1;
    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;
    assign m_tlast      = m_tlast_reg;

    // effective geometry
    logic [CW-1:0]  w_eff;
    logic [RW-1:0]  h_eff;
    logic [RDW-1:0] r_eff;

    always_comb
    begin
        if (cfg_width_reg == 11'd0)
            w_eff = CW'(1);
        else if (32'(cfg_width_reg) > 32'(MAX_WIDTH))
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(cfg_width_reg);
        if (cfg_height_reg == 11'd0)
            h_eff = RW'(1);
        else if (32'(cfg_height_reg) > 32'(MAX_HEIGHT))
            h_eff = RW'(MAX_HEIGHT);
        else
            h_eff = RW'(cfg_height_reg);
        if (32'(cfg_radius_reg) > 32'(MAX_RADIUS))
            r_eff = RDW'(MAX_RADIUS);
        else
            r_eff = RDW'(cfg_radius_reg);
    end

    // input counter advance
    logic           pix_take;
    logic [CW-1:0]  in_col_inc;
    logic           in_col_wrap;

    assign pix_take    = s_fire && (s_tuser == bfg_pkg::REQ_PIXEL) && (in_row_reg < h_eff);
    assign in_col_inc  = in_col_reg + CW'(1);
    assign in_col_wrap = (in_col_inc >= w_eff);

    // readiness of the next output
    logic [RW:0] pr;
    logic [CW:0] pc;
    logic        out_ready;

    always_comb
    begin
        pr = (RW+1)'(out_row_reg) + (RW+1)'(r_eff);
        if (pr > (RW+1)'(h_eff - RW'(1)))
            pr = (RW+1)'(h_eff - RW'(1));
        pc = (CW+1)'(out_col_reg) + (CW+1)'(r_eff);
        if (pc > (CW+1)'(w_eff - CW'(1)))
            pc = (CW+1)'(w_eff - CW'(1));
        out_ready = (in_row_reg >= h_eff) || (pr < (RW+1)'(in_row_reg)) ||
                    ((pr == (RW+1)'(in_row_reg)) && (pc < (CW+1)'(in_col_reg)));
    end

    // neighbor tap position
    logic signed [RW+1:0]  nr;
    logic signed [CW+1:0]  nc;
    logic signed [RGW+1:0] nring_s;
    logic                  tap_inb;
    logic [LAW-1:0]        tap_addr, ctr_addr, in_addr;
    logic [RDW-1:0]        adr, adc;
    logic [7:0]            dist_sq;
    logic [3:0]            sidx;
    logic [WB-1:0]         ws_sel;
    logic signed [DW-1:0]  rad_s;
    logic                  tap_last_col, tap_last, tap_in_window;

    always_comb
    begin
        nr = $signed({2'b00, out_row_reg}) + (RW+2)'(dr_reg);
        nc = $signed({2'b00, out_col_reg}) + (CW+2)'(dc_reg);
        tap_inb = (nr >= 0) && (nc >= 0) && (nr < $signed({2'b00, h_eff})) &&
                  (nc < $signed({2'b00, w_eff}));
        nring_s = $signed({2'b00, out_ring_reg}) + (RGW+2)'(dr_reg);
        if (nring_s < 0)
            nring_s = nring_s + (RGW+2)'(RING);
        else if (nring_s >= (RGW+2)'(RING))
            nring_s = nring_s - (RGW+2)'(RING);
        tap_addr = LAW'(nring_s[RGW-1:0]) * LAW'(MAX_WIDTH) + LAW'(nc[CW-1:0]);
        ctr_addr = LAW'(out_ring_reg) * LAW'(MAX_WIDTH) + LAW'(out_col_reg);
        in_addr  = LAW'(in_ring_reg) * LAW'(MAX_WIDTH) + LAW'(in_col_reg);
        adr = RDW'((dr_reg < 0) ? -dr_reg : dr_reg);
        adc = RDW'((dc_reg < 0) ? -dc_reg : dc_reg);
        dist_sq = 8'(adr) * 8'(adr) + 8'(adc) * 8'(adc);
        sidx = bfg_pkg::isqrt8(dist_sq);
        if (32'(sidx) < SPATIAL_DEPTH)
            ws_sel = spatial_reg[sidx[SIW-1:0]];
        else
            ws_sel = '0;
        rad_s = DW'($signed({1'b0, r_eff}));
        tap_last_col = (dc_reg == rad_s);
        tap_last     = tap_last_col && (dr_reg == rad_s);
        tap_in_window = (dr_reg <= rad_s) && (dr_reg >= -rad_s) &&
                        (dc_reg <= rad_s) && (dc_reg >= -rad_s);
    end

    // line store
    logic [7:0] line_rdata;
    logic [LAW-1:0] line_raddr;

    assign line_raddr = (state_reg == S_CTR_RD) ? ctr_addr : tap_addr;

    bfg_ram #(
        .WIDTH (8),
        .DEPTH (LDEP)
    ) u_line_ram (
        .clk   (clk),
        .we    (pix_take),
        .waddr (in_addr),
        .wdata (pixel_in),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    // range weight table
    logic [WB-1:0] range_rdata;
    logic [7:0]    diff;

    assign diff = (ip_reg > line_rdata) ? (ip_reg - line_rdata) : (line_rdata - ip_reg);

    bfg_ram #(
        .WIDTH (WB),
        .DEPTH (256)
    ) u_range_ram (
        .clk   (clk),
        .we    (s_fire && (s_tuser == bfg_pkg::REQ_RANGE_LOAD)),
        .waddr (table_index),
        .wdata (wv),
        .raddr (diff),
        .rdata (range_rdata)
    );

    // divider step
    logic [REMW-1:0] div_shift;
    logic            div_hit;

    assign div_shift = REMW'(den_reg) << div_k_reg;
    assign div_hit   = (rem_reg >= div_shift);

    // output counter advance
    logic [CW-1:0]  out_col_inc;
    logic [RW-1:0]  out_row_inc;
    logic           out_col_wrap, frame_end, emit_go;

    assign out_col_inc  = out_col_reg + CW'(1);
    assign out_col_wrap = (out_col_inc >= w_eff);
    assign out_row_inc  = out_row_reg + RW'(1);
    assign frame_end    = out_col_wrap && (out_row_inc >= h_eff);
    assign emit_go      = (state_reg == S_EMIT) && (!m_tvalid_reg || m_tready);

    // spatial weight table
    always_ff @(posedge clk)
    begin
        if (s_fire && (s_tuser == bfg_pkg::REQ_SPATIAL_LOAD) &&
            (32'(table_index) < SPATIAL_DEPTH))
        begin
            spatial_reg[table_index[SIW-1:0]] <= wv;
        end
    end

    // tap walk and divide datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_CHECK:
            begin
                dr_reg  <= -rad_s;
                dc_reg  <= -rad_s;
                num_reg <= '0;
                den_reg <= '0;
            end
            S_CTR_CAP:
            begin
                ip_reg <= line_rdata;
            end
            S_TAP_RD:
            begin
                ws_reg <= ws_sel;
                if (!tap_inb && !tap_last)
                begin
                    dc_reg <= tap_last_col ? -rad_s : dc_reg + DW'(1);
                    dr_reg <= tap_last_col ? dr_reg + DW'(1) : dr_reg;
                end
            end
            S_TAP_LINE:
            begin
                iq_reg <= line_rdata;
            end
            S_TAP_RANGE:
            begin
                wt_reg <= PW'(ws_reg) * PW'(range_rdata);
            end
            S_TAP_ACC:
            begin
                num_reg <= num_reg + NUMW'(wt_reg) * NUMW'(iq_reg);
                den_reg <= den_reg + DENW'(wt_reg);
                if (!tap_last)
                begin
                    dc_reg <= tap_last_col ? -rad_s : dc_reg + DW'(1);
                    dr_reg <= tap_last_col ? dr_reg + DW'(1) : dr_reg;
                end
            end
            S_DIV_INIT:
            begin
                rem_reg   <= REMW'(num_reg);
                q_reg     <= '0;
                div_k_reg <= 4'(QW - 1);
            end
            S_DIV:
            begin
                if (div_hit)
                begin
                    rem_reg          <= rem_reg - div_shift;
                    q_reg[div_k_reg] <= 1'b1;
                end
                div_k_reg <= div_k_reg - 4'd1;
            end
            default:
            begin
            end
        endcase
    end

    // sequencer, counters, configuration and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cfg_width_reg  <= 11'd1024;
            cfg_height_reg <= 11'd1024;
            cfg_radius_reg <= 3'd4;
            in_row_reg     <= '0;
            in_col_reg     <= '0;
            in_ring_reg    <= '0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            out_ring_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tlast_reg    <= 1'b0;
            m_tdata_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    bfg_pkg::CFG_WIDTH:  cfg_width_reg  <= cfg_data;
                    bfg_pkg::CFG_HEIGHT: cfg_height_reg <= cfg_data;
                    bfg_pkg::CFG_RADIUS: cfg_radius_reg <= cfg_data[2:0];
                    default:
                    begin
                    end
                endcase
            end

            // output valid: load on emit, drop once the beat is taken
            if (emit_go)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (pix_take)
                    begin
                        in_col_reg <= in_col_wrap ? '0 : in_col_inc;
                        if (in_col_wrap)
                        begin
                            in_row_reg  <= in_row_reg + RW'(1);
                            in_ring_reg <= (32'(in_ring_reg) == RING - 1) ? '0 :
                                           in_ring_reg + RGW'(1);
                        end
                    end
                    if (s_fire && ((s_tuser == bfg_pkg::REQ_PIXEL) ||
                                   (s_tuser == bfg_pkg::REQ_FLUSH)))
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (out_row_reg >= h_eff)
                    begin
                        in_row_reg   <= '0;
                        in_col_reg   <= '0;
                        in_ring_reg  <= '0;
                        out_row_reg  <= '0;
                        out_col_reg  <= '0;
                        out_ring_reg <= '0;
                        state_reg    <= S_IDLE;
                    end
                    else if (out_ready)
                        state_reg <= S_CTR_RD;
                    else
                        state_reg <= S_IDLE;
                end
                S_CTR_RD:    state_reg <= S_CTR_CAP;
                S_CTR_CAP:   state_reg <= S_TAP_RD;
                S_TAP_RD:
                begin
                    if (tap_inb)
                        state_reg <= S_TAP_LINE;
                    else if (tap_last)
                        state_reg <= S_DIV_INIT;
                end
                S_TAP_LINE:  state_reg <= S_TAP_RANGE;
                S_TAP_RANGE: state_reg <= S_TAP_ACC;
                S_TAP_ACC:   state_reg <= tap_last ? S_DIV_INIT : S_TAP_RD;
                S_DIV_INIT:  state_reg <= (den_reg == '0) ? S_EMIT : S_DIV;
                S_DIV:
                begin
                    if (div_k_reg == 4'd0)
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (emit_go)
                    begin
                        m_tlast_reg  <= frame_end;
                        if (den_reg == '0)
                            m_tdata_reg <= 8'd0;
                        else if (q_reg > QW'(255))
                            m_tdata_reg <= 8'd255;
                        else
                            m_tdata_reg <= q_reg[7:0];
                        if (frame_end)
                        begin
                            in_row_reg   <= '0;
                            in_col_reg   <= '0;
                            in_ring_reg  <= '0;
                            out_row_reg  <= '0;
                            out_col_reg  <= '0;
                            out_ring_reg <= '0;
                        end
                        else
                        begin
                            out_col_reg <= out_col_wrap ? '0 : out_col_inc;
                            if (out_col_wrap)
                            begin
                                out_row_reg  <= out_row_inc;
                                out_ring_reg <= (32'(out_ring_reg) == RING - 1) ? '0 :
                                                out_ring_reg + RGW'(1);
                            end
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:     state_reg <= S_IDLE;
            endcase
        end
    end

    // checks
    `BFG_ASSERT_SAME(a_out_from_emit, $rose(m_tvalid_reg), $past(state_reg == S_EMIT))
    `BFG_ASSERT_NEXT(a_frame_end_clears, emit_go && frame_end,
                     (in_row_reg == '0) && (out_row_reg == '0) && m_tlast_reg)
    `BFG_ASSERT_SAME(a_tap_in_window, state_reg == S_TAP_RD, tap_in_window)

endmodule
